[rtl/core/brld_pkg.sv]
// Shared types and constants for the bilevel run-length decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package brld_pkg;

    localparam int CODE_W  = 8;
    localparam int COLOR_W = 16;
    localparam int LEN_W   = 15;
    localparam int FRAME_W = 17;
    localparam int PIX_W   = 18;
    localparam int HIGH_W  = 7;
    localparam int SUM_W   = PIX_W + 1;

    // bit 7 of a code byte marks the first byte of a long run
    localparam int LONG_BIT = 7;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [COLOR_W-1:0] BACK_COLOR_RST   = 16'h0000;
    localparam logic [COLOR_W-1:0] FORE_COLOR_RST   = 16'hFFFF;
    localparam logic [FRAME_W-1:0] FRAME_PIXELS_RST = FRAME_W'(320 * 240);

    typedef enum logic [1:0] {
        REG_BACK_COLOR   = 2'd0,
        REG_FORE_COLOR   = 2'd1,
        REG_FRAME_PIXELS = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [COLOR_W-1:0] back_color;
        logic [COLOR_W-1:0] fore_color;
        logic [FRAME_W-1:0] frame_pixels;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/core/brld_code_if.sv]
// Request channel carrying one byte of the run-length stream.
// Depends on brld_pkg for the byte width.
`default_nettype none

interface brld_code_if;
    import brld_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink   (input valid, input code_byte, output ready);
endinterface

`default_nettype wire

[rtl/core/brld_run_if.sv]
// Request channel carrying one decoded run descriptor.
// Depends on brld_pkg for the field widths.
`default_nettype none

interface brld_run_if;
    import brld_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] run_color;
    logic [LEN_W-1:0]   run_length;
    logic               frame_end;

    modport source (output valid, output run_color, output run_length, output frame_end,
                    input ready);
    modport sink   (input valid, input run_color, input run_length, input frame_end,
                    output ready);
endinterface

`default_nettype wire

[rtl/core/bilevel_run_length_decoder.sv]
// Top level of the bilevel run-length decoder: APB registers plus decode datapath.
// Depends on brld_pkg, brld_code_if, brld_run_if, brld_regs and brld_core.
//
//  channel | role           | carries
//  --------+----------------+--------------------------------------------
//  code    | request in     | code_byte
//  run     | request out    | run_color, run_length, frame_end
//  apb     | register slave | back_color, fore_color, frame_pixels
//
// One code byte is accepted per cycle unless a stall holds the byte register; each run
// is offered from the result register. The first byte of a long run gives no result.
// Throughput is set by the single decode stage between the byte and result registers.
// rst_n clears pipeline valids and decode state and restores register defaults.
// A stalled result holds; the byte register still takes one more byte behind it.
`default_nettype none

module bilevel_run_length_decoder (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [brld_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [brld_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [brld_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    brld_code_if.sink                             code,
    brld_run_if.source                            run
);
    import brld_pkg::*;

    cfg_t cfg;

    brld_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    brld_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .code  (code),
        .run   (run)
    );

endmodule

`default_nettype wire

[rtl/core/brld_regs.sv]
// APB configuration registers: colors and frame size, with read back.
// Depends on brld_pkg.
`default_nettype none

module brld_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [brld_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [brld_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [brld_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output brld_pkg::cfg_t                        cfg
);
    import brld_pkg::*;

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.back_color   <= BACK_COLOR_RST;
            cfg_reg.fore_color   <= FORE_COLOR_RST;
            cfg_reg.frame_pixels <= FRAME_PIXELS_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_BACK_COLOR:   cfg_reg.back_color   <= pwdata[COLOR_W-1:0];
                REG_FORE_COLOR:   cfg_reg.fore_color   <= pwdata[COLOR_W-1:0];
                REG_FRAME_PIXELS: cfg_reg.frame_pixels <= pwdata[FRAME_W-1:0];
                default:          ; // drop writes to unmapped addresses
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_BACK_COLOR:   prdata = APB_DATA_W'(cfg_reg.back_color);
            REG_FORE_COLOR:   prdata = APB_DATA_W'(cfg_reg.fore_color);
            REG_FRAME_PIXELS: prdata = APB_DATA_W'(cfg_reg.frame_pixels);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/brld_core.sv]
// Decode datapath: input byte register, run assembly and pixel count, result register.
// Depends on brld_pkg, brld_code_if and brld_run_if.
`default_nettype none

module brld_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire brld_pkg::cfg_t cfg,
    brld_code_if.sink     code,
    brld_run_if.source    run
);
    import brld_pkg::*;

    logic              byte_vld_reg, byte_vld_next;
    logic [CODE_W-1:0] byte_reg;

    logic              await_low_reg, await_low_next;
    logic [HIGH_W-1:0] high_reg, high_next;
    logic              use_fore_reg, use_fore_next;
    logic [PIX_W-1:0]  pix_reg, pix_next;

    logic               out_vld_reg, out_vld_next;
    logic [COLOR_W-1:0] color_reg;
    logic [LEN_W-1:0]   length_reg;
    logic               fend_reg;

    logic               advance;
    logic               fire;
    logic               long_start;
    logic [LEN_W-1:0]   len;
    logic [SUM_W-1:0]   total;
    logic               fend;
    logic [COLOR_W-1:0] color;

    // result slot is free or being emptied this cycle
    assign advance    = !out_vld_reg || run.ready;
    assign fire       = byte_vld_reg && advance;
    assign code.ready = !byte_vld_reg || advance;

    assign long_start = !await_low_reg && byte_reg[LONG_BIT];
    assign len        = await_low_reg ? {high_reg, byte_reg} : LEN_W'(byte_reg);
    assign total      = SUM_W'(pix_reg) + SUM_W'(len);
    assign fend       = total >= SUM_W'(cfg.frame_pixels);
    assign color      = use_fore_reg ? cfg.fore_color : cfg.back_color;

    always_comb
    begin
        byte_vld_next  = byte_vld_reg;
        await_low_next = await_low_reg;
        high_next      = high_reg;
        use_fore_next  = use_fore_reg;
        pix_next       = pix_reg;
        out_vld_next   = out_vld_reg;

        if (code.valid && code.ready)
            byte_vld_next = 1'b1;
        else if (advance)
            byte_vld_next = 1'b0;

        if (advance)
            out_vld_next = fire && !long_start;

        if (fire)
        begin
            if (long_start)
            begin
                // hold the upper bits until the low byte arrives
                await_low_next = 1'b1;
                high_next      = byte_reg[HIGH_W-1:0];
            end
            else
            begin
                await_low_next = 1'b0;
                high_next      = '0;
                if (fend)
                begin
                    pix_next      = '0;
                    use_fore_next = 1'b0;
                end
                else
                begin
                    pix_next      = total[PIX_W-1:0];
                    use_fore_next = !use_fore_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_vld_reg  <= 1'b0;
            await_low_reg <= 1'b0;
            high_reg      <= '0;
            use_fore_reg  <= 1'b0;
            pix_reg       <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            byte_vld_reg  <= byte_vld_next;
            await_low_reg <= await_low_next;
            high_reg      <= high_next;
            use_fore_reg  <= use_fore_next;
            pix_reg       <= pix_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (code.valid && code.ready)
            byte_reg <= code.code_byte;
        if (fire && !long_start)
        begin
            color_reg  <= color;
            length_reg <= len;
            fend_reg   <= fend;
        end
    end

    assign run.valid      = out_vld_reg;
    assign run.run_color  = color_reg;
    assign run.run_length = length_reg;
    assign run.frame_end  = fend_reg;

endmodule

`default_nettype wire

[rtl/core/brld_checker.sv]
// Port-level checks for the bilevel run-length decoder, bound to the top level.
// Depends on brld_pkg and bilevel_run_length_decoder.
`default_nettype none

module brld_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_ready,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic [brld_pkg::COLOR_W-1:0]    run_color,
    input wire logic [brld_pkg::LEN_W-1:0]      run_length,
    input wire logic                            frame_end,
    input wire logic                            psel,
    input wire logic                            penable,
    input wire logic                            pwrite,
    input wire logic [brld_pkg::APB_ADDR_W-1:0] paddr,
    input wire logic [brld_pkg::APB_DATA_W-1:0] pwdata,
    input wire logic [brld_pkg::APB_DATA_W-1:0] prdata
);
    import brld_pkg::*;

    // no result is offered while reset is asserted
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("run valid during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(run_color) && $stable(run_length) && $stable(frame_end)))
        else $error("stalled run changed");

    // with the result stalled and a byte taken, the byte register is full
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && in_valid && in_ready) |=> (in_ready == out_ready))
        else $error("byte register overrun");

    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && !pwrite && paddr[3:2] == REG_BACK_COLOR
         && $past(psel && penable && pwrite) && paddr == $past(paddr))
        |-> (prdata == APB_DATA_W'($past(pwdata[COLOR_W-1:0]))))
        else $error("back color read back mismatch");

endmodule

bind bilevel_run_length_decoder brld_checker u_brld_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (code.valid),
    .in_ready   (code.ready),
    .out_valid  (run.valid),
    .out_ready  (run.ready),
    .run_color  (run.run_color),
    .run_length (run.run_length),
    .frame_end  (run.frame_end),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata)
);

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for bilevel_run_length_decoder: code bytes in, run descriptors out.
// Predicts each run from its own decoder state and APB register copy; needs brld_pkg and both channel interfaces.

module tb;
    import brld_pkg::*;

    localparam int LONG_STALL   = 400;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BURST = 310;
    localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR = 4'hC;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [LEN_W-1:0]   len;
        logic               frame_end;
    } run_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    brld_code_if code_ch ();
    brld_run_if  run_ch ();

    bilevel_run_length_decoder uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .code    (code_ch),
        .run     (run_ch)
    );

    // decoder state and register copy used for prediction
    cfg_t              model_cfg;
    logic              pending_long;
    logic [HIGH_W-1:0] long_high;
    logic              fore_turn;
    logic [PIX_W-1:0]  pixel_total;

    logic [CODE_W-1:0] code_q[$];
    run_t              expected_runs[$];

    int error_count   = 0;
    int send_idle_pct = 14;
    int recv_idle_pct = 64;
    int stalls_asked  = 0;
    int stalls_done   = 0;
    int stall_left    = 0;
    int quiet_cycles  = 0;

    always #5 clk = ~clk;

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, what, want, got);
            error_count++;
        end
    endfunction

    function automatic void decode_byte(logic [CODE_W-1:0] b);
        logic [LEN_W-1:0] len;
        logic [SUM_W-1:0] total;
        run_t             r;
        if (!pending_long && b[LONG_BIT])
        begin
            long_high    = b[HIGH_W-1:0];
            pending_long = 1'b1;
            return;
        end
        len          = pending_long ? {long_high, b} : LEN_W'(b);
        pending_long = 1'b0;
        long_high    = '0;
        total        = SUM_W'(pixel_total) + SUM_W'(len);
        r.color      = fore_turn ? model_cfg.fore_color : model_cfg.back_color;
        r.len        = len;
        r.frame_end  = (total >= SUM_W'(model_cfg.frame_pixels));
        if (r.frame_end)
        begin
            pixel_total = '0;
            fore_turn   = 1'b0;
        end
        else
        begin
            pixel_total = total[PIX_W-1:0];
            fore_turn   = ~fore_turn;
        end
        expected_runs.push_back(r);
    endfunction

    function automatic logic [APB_ADDR_W-1:0] reg_addr(reg_idx_t idx);
        return {idx, 2'b00};
    endfunction

    // code byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_ch.valid     <= 1'b0;
            code_ch.code_byte <= '0;
        end
        else
        begin
            if (code_ch.valid && code_ch.ready)
                decode_byte(code_ch.code_byte);
            if (!code_ch.valid || code_ch.ready)
            begin
                if (code_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    code_ch.valid     <= 1'b1;
                    code_ch.code_byte <= code_q.pop_front();
                end
                else
                    code_ch.valid <= 1'b0;
            end
        end
    end

    // run monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_ch.ready <= 1'b0;
        else
        begin
            if (run_ch.valid && run_ch.ready)
            begin
                if (expected_runs.size() == 0)
                begin
                    $display("%0t: unexpected run: expected none actual color=%h len=%0d end=%b",
                             $time, run_ch.run_color, run_ch.run_length, run_ch.frame_end);
                    error_count++;
                end
                else
                begin
                    run_t want;
                    want = expected_runs.pop_front();
                    check_field("run_color", 32'(want.color), 32'(run_ch.run_color));
                    check_field("run_length", 32'(want.len), 32'(run_ch.run_length));
                    check_field("frame_end", 32'(want.frame_end), 32'(run_ch.frame_end));
                end
            end
            if (stalls_done != stalls_asked)
            begin
                stall_left = LONG_STALL;
                stalls_done++;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                run_ch.ready <= 1'b0;
            end
            else
                run_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // abort when no request moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (code_ch.valid && code_ch.ready) || (run_ch.valid && run_ch.ready)
            || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[bilevel_run_length_decoder] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (addr[APB_ADDR_W-1:2])
            REG_BACK_COLOR:   model_cfg.back_color   = data[COLOR_W-1:0];
            REG_FORE_COLOR:   model_cfg.fore_color   = data[COLOR_W-1:0];
            REG_FRAME_PIXELS: model_cfg.frame_pixels = data[FRAME_W-1:0];
            default: ;
        endcase
    endtask

    task automatic check_registers();
        reg_idx_t              idx;
        logic [APB_DATA_W-1:0] want;
        for (int i = 0; i < 3; i++)
        begin
            idx = reg_idx_t'(i);
            case (idx)
                REG_BACK_COLOR:   want = APB_DATA_W'(model_cfg.back_color);
                REG_FORE_COLOR:   want = APB_DATA_W'(model_cfg.fore_color);
                default:          want = APB_DATA_W'(model_cfg.frame_pixels);
            endcase
            @(posedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= reg_addr(idx);
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            check_field(idx.name(), want, prdata);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic write_settings(logic [COLOR_W-1:0] back, logic [COLOR_W-1:0] fore,
                                  logic [FRAME_W-1:0] frame);
        apb_write(reg_addr(REG_BACK_COLOR), APB_DATA_W'(back));
        apb_write(reg_addr(REG_FORE_COLOR), APB_DATA_W'(fore));
        apb_write(reg_addr(REG_FRAME_PIXELS), APB_DATA_W'(frame));
        check_registers();
    endtask

    task automatic queue_codes(logic [CODE_W-1:0] codes[$]);
        @(negedge clk);
        foreach (codes[i])
            code_q.push_back(codes[i]);
    endtask

    task automatic queue_random(int count);
        int                n;
        int                roll;
        logic [CODE_W-1:0] b;
        n = 0;
        @(negedge clk);
        while (n < count)
        begin
            roll = $urandom_range(99);
            if (roll < 10)
            begin
                code_q.push_back(CODE_W'($urandom_range(255)));
                n++;
            end
            else if (roll < 55)
            begin
                code_q.push_back(CODE_W'($urandom_range(127)));
                n++;
            end
            else
            begin
                // keep long runs short when frames are small so frame ends come often
                if (roll < 60)
                    b = CODE_W'({HIGH_W{1'b1}});
                else if (model_cfg.frame_pixels < 4096)
                    b = CODE_W'($urandom_range(7));
                else
                    b = CODE_W'($urandom_range(127));
                b[LONG_BIT] = 1'b1;
                code_q.push_back(b);
                code_q.push_back(CODE_W'($urandom_range(255)));
                n += 2;
            end
        end
    endtask

    // hold until every request is taken and every run has come back
    task automatic wait_drained();
        while (code_q.size() != 0 || code_ch.valid || expected_runs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [CODE_W-1:0]  seq[$];
        logic [COLOR_W-1:0] back_pick;
        logic [COLOR_W-1:0] fore_pick;
        logic [FRAME_W-1:0] frame_pick;

        model_cfg.back_color   = BACK_COLOR_RST;
        model_cfg.fore_color   = FORE_COLOR_RST;
        model_cfg.frame_pixels = FRAME_PIXELS_RST;
        pending_long = 1'b0;
        long_high    = '0;
        fore_turn    = 1'b0;
        pixel_total  = '0;

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // field extremes at reset settings; leave a long run half done
        seq = '{8'h00, 8'h7F, 8'h80, 8'h00, 8'hFF, 8'hFF, 8'h80, 8'hFF,
                8'hFF, 8'h00, 8'h01, 8'hC0, 8'h00, 8'h85};
        queue_codes(seq);
        wait_drained();

        // colors change while the long run is pending
        write_settings(16'hFFFF, 16'h0000, 17'd1000);
        apb_write(UNUSED_ADDR, '1);
        check_registers();
        seq = '{8'h00, 8'h7F, 8'h7F};
        queue_codes(seq);
        wait_drained();

        // drop frame size below the running total
        apb_write(reg_addr(REG_FRAME_PIXELS), APB_DATA_W'(100));
        seq = '{8'h00};
        queue_codes(seq);
        wait_drained();

        // zero frame size: every run ends a frame
        apb_write(reg_addr(REG_FRAME_PIXELS), '0);
        seq = '{8'h05, 8'h00};
        queue_codes(seq);
        wait_drained();

        write_settings(16'h0000, 16'hFFFF, 17'd1);
        seq = '{8'h00, 8'h01};
        queue_codes(seq);
        wait_drained();

        apb_write(reg_addr(REG_FRAME_PIXELS), APB_DATA_W'({FRAME_W{1'b1}}));
        seq = '{8'hFF, 8'hFF};
        queue_codes(seq);
        wait_drained();

        for (int p = 0; p < 3; p++)
        begin
            @(negedge clk);
            send_idle_pct = (p == 0) ? 14 : (p == 1) ? 64 : 0;
            recv_idle_pct = (p == 0) ? 64 : (p == 1) ? 14 : 0;
            for (int s = 0; s < 2; s++)
            begin
                wait_drained();
                back_pick = ($urandom_range(3) == 0) ? '0 :
                            ($urandom_range(2) == 0) ? '1 : COLOR_W'($urandom());
                fore_pick = ($urandom_range(3) == 0) ? '0 :
                            ($urandom_range(2) == 0) ? '1 : COLOR_W'($urandom());
                case ($urandom_range(9))
                    0:       frame_pick = FRAME_W'(1);
                    1:       frame_pick = '1;
                    2:       frame_pick = '0;
                    3, 4, 5: frame_pick = FRAME_W'($urandom_range(300, 2));
                    6, 7:    frame_pick = FRAME_W'($urandom_range(5000, 300));
                    default: frame_pick = FRAME_W'($urandom_range(131071, 1));
                endcase
                write_settings(back_pick, fore_pick, frame_pick);
                // back up the output while bytes keep coming
                if (p == 2 && s == 0)
                begin
                    @(negedge clk);
                    stalls_asked++;
                end
                queue_random(RANDOM_BURST);
            end
        end
        wait_drained();

        if (error_count == 0)
            $display("[bilevel_run_length_decoder] OK");
        else
            $display("[bilevel_run_length_decoder] ERROR");
        $finish;
    end

endmodule
